### rtl/grc_pkg.sv
// ============================================================================
// grc_pkg - shared types and constants for the grid ray caster
// Datapath widths, datapath operation codes, config register indexes, the
// control/status word types and the CORDIC arctangent table.
// ============================================================================
package grc_pkg;

    // Fixed-point widths (positions carry 16 fraction bits)
    localparam int POS_W   = 29;            // world position, up to 8192 px
    localparam int MAG_W   = 21;            // CORDIC magnitude
    localparam int DMAJ_W  = 23;            // distance to first crossing
    localparam int DIV_W   = DMAJ_W + MAG_W; // dividend / quotient
    localparam int NW      = DIV_W + 2;     // signed minor coordinate
    localparam int SQ_W    = 2 * POS_W + 1; // squared distance
    localparam int SQV_W   = SQ_W - 24;     // root operand after scaling
    localparam int CORDIC_STEPS = 14;
    localparam int SQRT_STEPS   = 18;

    // Datapath operations
    localparam logic [4:0] OP_NOP    = 5'd0;
    localparam logic [4:0] OP_CLEAR  = 5'd1;
    localparam logic [4:0] OP_LOAD   = 5'd2;
    localparam logic [4:0] OP_CORDIC = 5'd3;
    localparam logic [4:0] OP_FOLD   = 5'd4;
    localparam logic [4:0] OP_PTILE  = 5'd5;
    localparam logic [4:0] OP_PSETUP = 5'd6;
    localparam logic [4:0] OP_MUL1   = 5'd7;
    localparam logic [4:0] OP_DIV    = 5'd8;
    localparam logic [4:0] OP_SAVE   = 5'd9;
    localparam logic [4:0] OP_MUL2   = 5'd10;
    localparam logic [4:0] OP_NINIT  = 5'd11;
    localparam logic [4:0] OP_WT     = 5'd12;
    localparam logic [4:0] OP_WA     = 5'd13;
    localparam logic [4:0] OP_WC     = 5'd14;
    localparam logic [4:0] OP_DABS   = 5'd15;
    localparam logic [4:0] OP_DSQX   = 5'd16;
    localparam logic [4:0] OP_DSQY   = 5'd17;
    localparam logic [4:0] OP_DSUM   = 5'd18;
    localparam logic [4:0] OP_PICK   = 5'd19;
    localparam logic [4:0] OP_SQRT   = 5'd20;

    // Register indexes on the config port
    localparam logic REG_MAP_COLS = 1'b0;
    localparam logic REG_MAP_ROWS = 1'b1;

    typedef struct packed {
        logic [4:0] op;
        logic       vert;     // 1 while the vertical pass runs
    } cmd_t;

    typedef struct packed {
        logic den_zero;       // slope degenerate for this pass
        logic brk;            // ray left the walk window
        logic hit;            // probe found a wall or reached the map edge
    } stat_t;

    // Arctangent table in binary-angle units
    function automatic logic signed [16:0] atan_f(input logic [3:0] i);
        logic signed [16:0] v;
        case (i)
            4'd0:    v = 17'sd8192;
            4'd1:    v = 17'sd4836;
            4'd2:    v = 17'sd2555;
            4'd3:    v = 17'sd1297;
            4'd4:    v = 17'sd651;
            4'd5:    v = 17'sd326;
            4'd6:    v = 17'sd163;
            4'd7:    v = 17'sd81;
            4'd8:    v = 17'sd41;
            4'd9:    v = 17'sd20;
            4'd10:   v = 17'sd10;
            4'd11:   v = 17'sd5;
            4'd12:   v = 17'sd3;
            4'd13:   v = 17'sd1;
            default: v = 17'sd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/grc_ctrl.sv
// ============================================================================
// grc_ctrl - sequencer of the grid ray caster
// Walks the map clear, the CORDIC, both crossing passes, the distance
// squares and the root, issuing one datapath operation per cycle.
// ============================================================================
module grc_ctrl #(
    parameter int MAX_COLS = 32,
    parameter int MAX_ROWS = 16,
    parameter int CNT_W    = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               func,
    input  grc_pkg::stat_t     stat,
    output grc_pkg::cmd_t      cmd,
    output logic [CNT_W-1:0]   cnt,
    output logic               busy,
    output logic               done
);
    import grc_pkg::*;

    localparam int DEPTH    = MAX_ROWS * MAX_COLS;
    localparam int STEP_CAP = MAX_ROWS + MAX_COLS + 4;

    localparam logic [4:0] S_CLEAR  = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_CORDIC = 5'd2;
    localparam logic [4:0] S_FOLD   = 5'd3;
    localparam logic [4:0] S_PTILE  = 5'd4;
    localparam logic [4:0] S_PSETUP = 5'd5;
    localparam logic [4:0] S_MUL1   = 5'd6;
    localparam logic [4:0] S_DIV1   = 5'd7;
    localparam logic [4:0] S_SAVE   = 5'd8;
    localparam logic [4:0] S_MUL2   = 5'd9;
    localparam logic [4:0] S_DIV2   = 5'd10;
    localparam logic [4:0] S_NINIT  = 5'd11;
    localparam logic [4:0] S_WT     = 5'd12;
    localparam logic [4:0] S_WA     = 5'd13;
    localparam logic [4:0] S_WC     = 5'd14;
    localparam logic [4:0] S_DABS   = 5'd15;
    localparam logic [4:0] S_DSQX   = 5'd16;
    localparam logic [4:0] S_DSQY   = 5'd17;
    localparam logic [4:0] S_DSUM   = 5'd18;
    localparam logic [4:0] S_PEND   = 5'd19;
    localparam logic [4:0] S_PICK   = 5'd20;
    localparam logic [4:0] S_SQRT   = 5'd21;
    localparam logic [4:0] S_OUT    = 5'd22;

    logic [4:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             vert_reg, vert_next;

    // State and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
            vert_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            vert_reg  <= vert_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        vert_next  = vert_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DEPTH - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start && !func)
                begin
                    cnt_next   = '0;
                    vert_next  = 1'b0;
                    state_next = S_CORDIC;
                end
            end
            S_CORDIC:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CORDIC_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_FOLD;
                end
            end
            S_FOLD:   state_next = S_PTILE;
            S_PTILE:  state_next = S_PSETUP;
            S_PSETUP: state_next = stat.den_zero ? S_PEND : S_MUL1;
            S_MUL1:
            begin
                cnt_next   = '0;
                state_next = S_DIV1;
            end
            S_DIV1:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_W - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_SAVE;
                end
            end
            S_SAVE:   state_next = S_MUL2;
            S_MUL2:
            begin
                cnt_next   = '0;
                state_next = S_DIV2;
            end
            S_DIV2:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_W - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_NINIT;
                end
            end
            S_NINIT:
            begin
                cnt_next   = '0;
                state_next = S_WT;
            end
            S_WT:     state_next = stat.brk ? S_PEND : S_WA;
            S_WA:     state_next = S_WC;
            S_WC:
            begin
                if (stat.hit)
                    state_next = S_DABS;
                else if (cnt_reg == CNT_W'(STEP_CAP - 1))
                    state_next = S_PEND;
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_WT;
                end
            end
            S_DABS:   state_next = S_DSQX;
            S_DSQX:   state_next = S_DSQY;
            S_DSQY:   state_next = S_DSUM;
            S_DSUM:   state_next = S_PEND;
            S_PEND:
            begin
                if (vert_reg)
                    state_next = S_PICK;
                else
                begin
                    vert_next  = 1'b1;
                    state_next = S_PTILE;
                end
            end
            S_PICK:
            begin
                cnt_next   = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_OUT;
                end
            end
            S_OUT:    state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Operation decode
    always_comb
    begin
        cmd.vert = vert_reg;
        unique case (state_reg)
            S_CLEAR:  cmd.op = OP_CLEAR;
            S_IDLE:   cmd.op = start ? OP_LOAD : OP_NOP;
            S_CORDIC: cmd.op = OP_CORDIC;
            S_FOLD:   cmd.op = OP_FOLD;
            S_PTILE:  cmd.op = OP_PTILE;
            S_PSETUP: cmd.op = OP_PSETUP;
            S_MUL1:   cmd.op = OP_MUL1;
            S_DIV1:   cmd.op = OP_DIV;
            S_SAVE:   cmd.op = OP_SAVE;
            S_MUL2:   cmd.op = OP_MUL2;
            S_DIV2:   cmd.op = OP_DIV;
            S_NINIT:  cmd.op = OP_NINIT;
            S_WT:     cmd.op = OP_WT;
            S_WA:     cmd.op = OP_WA;
            S_WC:     cmd.op = OP_WC;
            S_DABS:   cmd.op = OP_DABS;
            S_DSQX:   cmd.op = OP_DSQX;
            S_DSQY:   cmd.op = OP_DSQY;
            S_DSUM:   cmd.op = OP_DSUM;
            S_PICK:   cmd.op = OP_PICK;
            S_SQRT:   cmd.op = OP_SQRT;
            default:  cmd.op = OP_NOP;
        endcase
    end

    assign cnt  = cnt_reg;
    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_OUT);

    // Checks
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_cast_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !func) |=> (busy && !done))
        else $error("cast word not taken");

    a_walk_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WC) |-> (cnt_reg < CNT_W'(STEP_CAP)))
        else $error("crossing count beyond cap");

endmodule

### rtl/grc_datapath.sv
// ============================================================================
// grc_datapath - arithmetic and map store of the grid ray caster
// CORDIC, tile index unit, bit-serial divider, crossing walk with the map
// memory, squared distance multiplier and bit-serial square root.
// ============================================================================
module grc_datapath #(
    parameter int TILE_SIZE = 32,
    parameter int MAX_COLS  = 32,
    parameter int MAX_ROWS  = 16,
    parameter int CNT_W     = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  grc_pkg::cmd_t      cmd,
    input  logic [CNT_W-1:0]   cnt,
    input  logic               func,
    input  logic [15:0]        ray_angle,
    input  logic [13:0]        player_x,
    input  logic [12:0]        player_y,
    input  logic [9:0]         ray_index,
    input  logic [3:0]         cell_row,
    input  logic [4:0]         cell_col,
    input  logic [3:0]         cell_value,
    input  logic               cfg_valid,
    input  logic               cfg_index,
    input  logic [5:0]         cfg_data,
    output grc_pkg::stat_t     stat,
    output logic [9:0]         strip,
    output logic [14:0]        distance,
    output logic [14:0]        hit_x,
    output logic [13:0]        hit_y,
    output logic [3:0]         hit_content,
    output logic               hit_vertical,
    output logic               hit_found,
    output logic               facing_down,
    output logic               facing_right
);
    import grc_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RECIP = (1 << 18) / TILE_SIZE;

    // Config registers
    logic [5:0] cols_reg;
    logic [4:0] rows_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= 6'd20;
            rows_reg <= 5'd14;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_MAP_COLS)
                cols_reg <= cfg_data;
            else
                rows_reg <= cfg_data[4:0];
        end
    end

    // Clamp to 1..MAX
    logic [6:0] used_cols, used_rows;
    always_comb
    begin
        if (cols_reg == 6'd0)
            used_cols = 7'd1;
        else if (32'(cols_reg) > MAX_COLS)
            used_cols = 7'(MAX_COLS);
        else
            used_cols = {1'b0, cols_reg};
        if (rows_reg == 5'd0)
            used_rows = 7'd1;
        else if (32'(rows_reg) > MAX_ROWS)
            used_rows = 7'(MAX_ROWS);
        else
            used_rows = {2'b0, rows_reg};
    end

    // Datapath registers
    logic [15:0]              angle_reg;
    logic [POS_W-1:0]         px_reg, py_reg;
    logic [9:0]               strip_reg;
    logic signed [22:0]       cx_reg, cy_reg;
    logic signed [16:0]       cz_reg;
    logic [MAG_W-1:0]         cm_reg, sm_reg;
    logic [10:0]              tile_reg;
    logic signed [12:0]       mi_reg;
    logic [DMAJ_W-1:0]        dmaj_reg;
    logic [DIV_W-1:0]         dnum_reg, quot_reg, dmin_reg;
    logic [MAG_W-1:0]         rem_reg;
    logic signed [NW-1:0]     n_reg, nstep_reg;
    logic                     outside_reg;
    logic [3:0]               rd_reg;
    logic [POS_W-1:0]         hhx_reg, hhy_reg, vhx_reg, vhy_reg;
    logic [3:0]               hc_reg, vc_reg;
    logic                     hf_reg, vf_reg;
    logic [POS_W-1:0]         dx_reg, dy_reg;
    logic [2*POS_W-1:0]       sqa_reg, sqb_reg;
    logic [SQ_W-1:0]          hs_reg, vs_reg;
    logic [POS_W-1:0]         bx_reg, by_reg;
    logic [3:0]               bc_reg;
    logic                     pickv_reg, found_reg;
    logic [SQV_W-1:0]         sv_reg, sr_reg, sb_reg;

    // Facing flags
    logic down, right;
    assign down  = (angle_reg != 16'd0) && !angle_reg[15];
    assign right = (angle_reg < 16'd16384) || (angle_reg > 16'd49152);

    // Pass operand selection
    logic             vert, maj_pos, min_pos;
    logic [POS_W-1:0] pmaj, pmin;
    logic [MAG_W-1:0] num, den;
    logic [6:0]       used_maj, used_min;
    logic [POS_W-1:0] lim_min_fx;
    logic [31:0]      lim_px;

    assign vert     = cmd.vert;
    assign maj_pos  = vert ? right : down;
    assign min_pos  = vert ? down : right;
    assign pmaj     = vert ? px_reg : py_reg;
    assign pmin     = vert ? py_reg : px_reg;
    assign num      = vert ? sm_reg : cm_reg;
    assign den      = vert ? cm_reg : sm_reg;
    assign used_maj = vert ? used_cols : used_rows;
    assign used_min = vert ? used_rows : used_cols;
    assign lim_px     = {25'b0, used_min} * TILE_SIZE;
    assign lim_min_fx = {lim_px[12:0], 16'b0};

    // Tile index: floor(px / TILE_SIZE) by reciprocal and one correction
    logic [12:0] tile_in;
    logic [31:0] tprod, tback, trem;
    logic [10:0] tq0, tq;
    always_comb
    begin
        tile_in = (cmd.op == OP_WT) ? n_reg[28:16] : pmaj[28:16];
        tprod   = {19'b0, tile_in} * 32'(RECIP);
        tq0     = tprod[28:18];
        tback   = {21'b0, tq0} * TILE_SIZE;
        trem    = {19'b0, tile_in} - tback;
        tq      = (trem >= 32'(TILE_SIZE)) ? tq0 + 11'd1 : tq0;
    end

    // Major line position from its tile index
    logic [31:0]      mi_px_w;
    logic [POS_W-1:0] m_fx;
    assign mi_px_w = {20'b0, mi_reg[11:0]} * TILE_SIZE;
    assign m_fx    = {mi_px_w[12:0], 16'b0};

    // First crossing setup
    logic [12:0]      t1;
    logic [31:0]      m0_px;
    logic [POS_W-1:0] m0_fx, dmaj_w;
    always_comb
    begin
        t1     = {2'b0, tile_reg} + {12'b0, maj_pos};
        m0_px  = {19'b0, t1} * TILE_SIZE;
        m0_fx  = {m0_px[12:0], 16'b0};
        dmaj_w = maj_pos ? m0_fx - pmaj : pmaj - m0_fx;
    end

    // Walk window and probe
    logic signed [NW-1:0] lim_s;
    logic signed [12:0]   umaj_s, maj_idx;
    logic [11:0]          row_i, col_i;
    logic [31:0]          raddr_w;
    logic                 outside;
    always_comb
    begin
        lim_s    = $signed({{(NW-POS_W){1'b0}}, lim_min_fx});
        umaj_s   = $signed({6'b0, used_maj});
        maj_idx  = maj_pos ? mi_reg : mi_reg - 13'sd1;
        row_i    = vert ? {1'b0, tile_reg} : maj_idx[11:0];
        col_i    = vert ? maj_idx[11:0] : {1'b0, tile_reg};
        raddr_w  = {20'b0, row_i} * MAX_COLS + {20'b0, col_i};
        outside  = (!maj_pos && mi_reg == 13'sd0) || (maj_pos && mi_reg == umaj_s)
                   || (n_reg == lim_s);
    end

    assign stat.den_zero = (den == '0);
    assign stat.brk      = (mi_reg < 13'sd0) || (mi_reg > umaj_s) || n_reg[NW-1]
                           || (n_reg > lim_s);
    assign stat.hit      = outside_reg || (rd_reg != 4'd0);

    // CORDIC step
    logic [3:0]          ci;
    logic signed [22:0]  xs, ys;
    logic signed [16:0]  at;
    logic [22:0]         ax, ay;
    assign ci = cnt[3:0];
    assign xs = cx_reg >>> ci;
    assign ys = cy_reg >>> ci;
    assign at = atan_f(ci);
    assign ax = cx_reg[22] ? 23'(-cx_reg) : 23'(cx_reg);
    assign ay = (cy_reg[22] ? 23'(-cy_reg) : 23'(cy_reg)) & {23{angle_reg[13:0] != 14'd0}};

    // Divider step
    logic [MAG_W:0] rem_sh, rem_sub;
    logic           ge;
    assign rem_sh  = {rem_reg, dnum_reg[DIV_W-1]};
    assign ge      = rem_sh >= {1'b0, den};
    assign rem_sub = rem_sh - {1'b0, den};

    // Crossing distance products
    logic [DIV_W-1:0] mul1, mul2;
    assign mul1 = DIV_W'(dmaj_reg) * DIV_W'(num);
    assign mul2 = (DIV_W'(num) * DIV_W'(TILE_SIZE)) << 16;

    // Squared distance
    logic [POS_W-1:0]   hx_sel, hy_sel, msq_in;
    logic [2*POS_W-1:0] msq;
    assign hx_sel = vert ? vhx_reg : hhx_reg;
    assign hy_sel = vert ? vhy_reg : hhy_reg;
    assign msq_in = (cmd.op == OP_DSQY) ? dy_reg : dx_reg;
    assign msq    = (2*POS_W)'(msq_in) * (2*POS_W)'(msq_in);

    // Pick and root
    logic            pickv;
    logic [SQ_W-1:0] best;
    logic [SQV_W-1:0] st;
    assign pickv = vf_reg && (!hf_reg || vs_reg < hs_reg);
    assign best  = pickv ? vs_reg : (hf_reg ? hs_reg : '0);
    assign st    = sr_reg + sb_reg;

    // Sequenced registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                if (!func)
                begin
                    angle_reg <= ray_angle;
                    px_reg    <= {3'b0, player_x, 12'b0};
                    py_reg    <= {4'b0, player_y, 12'b0};
                    strip_reg <= ray_index;
                    cx_reg    <= 23'sd1048576;
                    cy_reg    <= '0;
                    cz_reg    <= $signed({3'b0, ray_angle[13:0]});
                    hf_reg    <= 1'b0;
                    vf_reg    <= 1'b0;
                end
            end
            OP_CORDIC:
            begin
                if (!cz_reg[16])
                begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - at;
                end
                else
                begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + at;
                end
            end
            OP_FOLD:
            begin
                cm_reg <= angle_reg[14] ? ay[MAG_W-1:0] : ax[MAG_W-1:0];
                sm_reg <= angle_reg[14] ? ax[MAG_W-1:0] : ay[MAG_W-1:0];
            end
            OP_PTILE: tile_reg <= tq;
            OP_PSETUP:
            begin
                mi_reg   <= $signed(t1);
                dmaj_reg <= dmaj_w[DMAJ_W-1:0];
            end
            OP_MUL1:
            begin
                dnum_reg <= mul1;
                rem_reg  <= '0;
            end
            OP_MUL2:
            begin
                dnum_reg <= mul2;
                rem_reg  <= '0;
            end
            OP_DIV:
            begin
                rem_reg  <= ge ? rem_sub[MAG_W-1:0] : rem_sh[MAG_W-1:0];
                quot_reg <= {quot_reg[DIV_W-2:0], ge};
                dnum_reg <= {dnum_reg[DIV_W-2:0], 1'b0};
            end
            OP_SAVE: dmin_reg <= quot_reg;
            OP_NINIT:
            begin
                n_reg <= min_pos
                    ? $signed({{(NW-POS_W){1'b0}}, pmin}) + $signed({2'b0, dmin_reg})
                    : $signed({{(NW-POS_W){1'b0}}, pmin}) - $signed({2'b0, dmin_reg});
                nstep_reg <= min_pos ? $signed({2'b0, quot_reg})
                                     : -$signed({2'b0, quot_reg});
            end
            OP_WT: tile_reg <= tq;
            OP_WA: outside_reg <= outside;
            OP_WC:
            begin
                if (stat.hit)
                begin
                    if (vert)
                    begin
                        vhx_reg <= m_fx;
                        vhy_reg <= n_reg[POS_W-1:0];
                        vc_reg  <= outside_reg ? 4'd0 : rd_reg;
                        vf_reg  <= 1'b1;
                    end
                    else
                    begin
                        hhy_reg <= m_fx;
                        hhx_reg <= n_reg[POS_W-1:0];
                        hc_reg  <= outside_reg ? 4'd0 : rd_reg;
                        hf_reg  <= 1'b1;
                    end
                end
                else
                begin
                    mi_reg <= maj_pos ? mi_reg + 13'sd1 : mi_reg - 13'sd1;
                    n_reg  <= n_reg + nstep_reg;
                end
            end
            OP_DABS:
            begin
                dx_reg <= (hx_sel >= px_reg) ? hx_sel - px_reg : px_reg - hx_sel;
                dy_reg <= (hy_sel >= py_reg) ? hy_sel - py_reg : py_reg - hy_sel;
            end
            OP_DSQX: sqa_reg <= msq;
            OP_DSQY: sqb_reg <= msq;
            OP_DSUM:
            begin
                if (vert)
                    vs_reg <= SQ_W'(sqa_reg) + SQ_W'(sqb_reg);
                else
                    hs_reg <= SQ_W'(sqa_reg) + SQ_W'(sqb_reg);
            end
            OP_PICK:
            begin
                pickv_reg <= pickv;
                found_reg <= hf_reg || vf_reg;
                bx_reg    <= pickv ? vhx_reg : (hf_reg ? hhx_reg : '0);
                by_reg    <= pickv ? vhy_reg : (hf_reg ? hhy_reg : '0);
                bc_reg    <= pickv ? vc_reg : (hf_reg ? hc_reg : 4'd0);
                sv_reg    <= best[SQ_W-1:24];
                sr_reg    <= '0;
                sb_reg    <= SQV_W'(1) << (SQV_W - 1);
            end
            OP_SQRT:
            begin
                if (sv_reg >= st)
                begin
                    sv_reg <= sv_reg - st;
                    sr_reg <= (sr_reg >> 1) + sb_reg;
                end
                else
                    sr_reg <= sr_reg >> 1;
                sb_reg <= sb_reg >> 2;
            end
            default: ;
        endcase
    end

    // Map store: one write port, one registered read port
    logic [3:0]    mem [DEPTH];
    logic          we;
    logic [AW-1:0] waddr;
    logic [3:0]    wdata;
    logic [31:0]   waddr_w;
    always_comb
    begin
        waddr_w = {28'b0, cell_row} * MAX_COLS + {27'b0, cell_col};
        we      = 1'b0;
        waddr   = waddr_w[AW-1:0];
        wdata   = cell_value;
        if (cmd.op == OP_CLEAR)
        begin
            we    = 1'b1;
            waddr = cnt[AW-1:0];
            wdata = 4'd0;
        end
        else if (cmd.op == OP_LOAD && func)
            we = (32'(cell_row) < MAX_ROWS) && (32'(cell_col) < MAX_COLS);
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (cmd.op == OP_WA)
            rd_reg <= mem[raddr_w[AW-1:0]];
    end

    // Result fields
    assign strip        = strip_reg;
    assign distance     = (!found_reg || sr_reg > SQV_W'(32767)) ? 15'd32767
                                                                : sr_reg[14:0];
    assign hit_x        = bx_reg[26:12];
    assign hit_y        = by_reg[25:12];
    assign hit_content  = bc_reg;
    assign hit_vertical = pickv_reg;
    assign hit_found    = found_reg;
    assign facing_down  = down;
    assign facing_right = right;

endmodule

### rtl/grid_ray_caster_top.sv
// ============================================================================
// grid_ray_caster_top - tile map ray caster
// Controller plus datapath; stores map cells and casts one ray per word.
// ============================================================================
// A word is taken when start is high and busy is low. A map write (func 1)
// gives no result. A cast (func 0) runs the CORDIC and then, for each pass,
// two bit-serial divisions with 44-bit quotients, a crossing walk that
// probes at most MAX_ROWS+MAX_COLS+4 grid crossings (a tile index, a map
// memory read and a check for each) and, on a hit, the squared distance;
// the square root of the picked distance comes last. The result is shown for
// one cycle with done high and must be taken then; the receiver cannot
// stall. After reset the block is busy while the map memory is cleared.
// The config port is always ready and should be written only while the
// block is idle.
module grid_ray_caster_top #(
    parameter int TILE_SIZE = 32,
    parameter int MAX_COLS  = 32,
    parameter int MAX_ROWS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        func,
    input  logic [15:0] ray_angle,
    input  logic [13:0] player_x,
    input  logic [12:0] player_y,
    input  logic [9:0]  ray_index,
    input  logic [3:0]  cell_row,
    input  logic [4:0]  cell_col,
    input  logic [3:0]  cell_value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [5:0]  cfg_data,
    output logic        done,
    output logic [9:0]  strip,
    output logic [14:0] distance,
    output logic [14:0] hit_x,
    output logic [13:0] hit_y,
    output logic [3:0]  hit_content,
    output logic        hit_vertical,
    output logic        hit_found,
    output logic        facing_down,
    output logic        facing_right
);
    import grc_pkg::*;

    localparam int CNT_W = $clog2(MAX_ROWS * MAX_COLS + MAX_ROWS + MAX_COLS + DIV_W + 8);

    cmd_t             cmd;
    stat_t            stat;
    logic [CNT_W-1:0] cnt;

    assign cfg_ready = 1'b1;

    // Sequencer
    grc_ctrl #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (func),
        .stat  (stat),
        .cmd   (cmd),
        .cnt   (cnt),
        .busy  (busy),
        .done  (done)
    );

    // Arithmetic and map store
    grc_datapath #(
        .TILE_SIZE (TILE_SIZE),
        .MAX_COLS  (MAX_COLS),
        .MAX_ROWS  (MAX_ROWS),
        .CNT_W     (CNT_W)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cnt          (cnt),
        .func         (func),
        .ray_angle    (ray_angle),
        .player_x     (player_x),
        .player_y     (player_y),
        .ray_index    (ray_index),
        .cell_row     (cell_row),
        .cell_col     (cell_col),
        .cell_value   (cell_value),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .stat         (stat),
        .strip        (strip),
        .distance     (distance),
        .hit_x        (hit_x),
        .hit_y        (hit_y),
        .hit_content  (hit_content),
        .hit_vertical (hit_vertical),
        .hit_found    (hit_found),
        .facing_down  (facing_down),
        .facing_right (facing_right)
    );

endmodule
